// ===== src/assert_macros.svh =====
// assertion macros for the rtl files, included by gcnb_back
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define GCNB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define GCNB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/gcnb_pkg.sv =====
// types, constants and tables for the grid neighbor bin lister
// no dependencies
package gcnb_pkg;

   localparam int COORD_W   = 24;
   localparam int DIV_W     = COORD_W - 1;
   localparam int MAG_W     = COORD_W + 1;
   localparam int CNT_W     = $clog2(DIV_W);
   localparam int MAX_M     = 1024;
   localparam int M_W       = $clog2(MAX_M) + 1;
   localparam int HALF_W    = M_W - 1;
   localparam int MM_W      = 2 * M_W - 1;
   localparam int BIN_W     = COORD_W + 1;
   localparam int T_W       = BIN_W + M_W + 1;
   localparam int CENTER_W  = 48;
   localparam int IDX_W     = 30;
   localparam int TOT_W     = 31;
   localparam int BSZ_W     = 23;
   localparam int LIM_W     = 23;
   localparam int ST_W      = 2;
   localparam int ADDR_W    = 4;
   localparam int DATA_W    = 32;
   localparam int NB_N      = 9;
   localparam int PL_N      = 3;
   localparam int NB_W      = 4;
   localparam int PL_W      = 2;

   localparam logic [ST_W-1:0] ST_OK   = 2'd0;
   localparam logic [ST_W-1:0] ST_OOB  = 2'd1;
   localparam logic [ST_W-1:0] ST_NONE = 2'd2;

   localparam logic [1:0] REG_BIN_SIZE   = 2'd0;
   localparam logic [1:0] REG_BINS_AXIS  = 2'd1;
   localparam logic [1:0] REG_TOTAL_BINS = 2'd2;
   localparam logic [1:0] REG_COORD_LIM  = 2'd3;

   localparam logic [BSZ_W-1:0] BSZ_RESET = BSZ_W'(256);
   localparam logic [M_W-1:0]   BPA_RESET = M_W'(256);
   localparam logic [TOT_W-1:0] TOT_RESET = TOT_W'(16777216);
   localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(8388607);
   localparam logic [TOT_W-1:0] TOT_CAP   = TOT_W'(1073741824);

   // neighbor steps within one plane
   localparam logic signed [1:0] ROW_STEP [NB_N] = '{
      2'sd0, 2'sd0, 2'sd0, 2'sd1, -2'sd1, 2'sd1, 2'sd1, -2'sd1, -2'sd1};
   localparam logic signed [1:0] COL_STEP [NB_N] = '{
      2'sd0, 2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd1, -2'sd1, 2'sd1, -2'sd1};

   typedef struct packed {
      logic [BSZ_W-1:0]  dsz;
      logic [M_W-1:0]    m;
      logic [HALF_W-1:0] half;
      logic [MM_W-1:0]   mm;
      logic [TOT_W-1:0]  tot;
      logic [LIM_W-1:0]  lim;
   } cfg_type;

   typedef struct packed {
      logic                       is_err;
      logic signed [CENTER_W-1:0] center;
   } entry_type;

   typedef struct packed {
      logic      push;
      entry_type entry;
   } push_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

endpackage

// ===== src/gcnb_req_if.sv =====
// point transaction channel
// depends on gcnb_pkg
interface gcnb_req_if import gcnb_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] pos_x;
   logic signed [COORD_W-1:0] pos_y;
   logic signed [COORD_W-1:0] pos_z;
   modport source (output valid, pos_x, pos_y, pos_z, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

// ===== src/gcnb_rsp_if.sv =====
// bin result transaction channel
// depends on gcnb_pkg
interface gcnb_rsp_if import gcnb_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] bin_index;
   logic [ST_W-1:0]  status;
   logic             last;
   modport source (output valid, bin_index, status, last, input ready);
   modport sink (input valid, bin_index, status, last, output ready);
endinterface

// ===== src/grid_cell_neighbor_bins.sv =====
// top level of the 27-neighbor bin lister for a uniform 3d grid
// depends on gcnb_pkg, gcnb_req_if, gcnb_rsp_if, gcnb_csr, gcnb_front, gcnb_queue, gcnb_back
//
//   channel  direction  contents
//   req_ch   in         pos_x, pos_y, pos_z (signed q15.8)
//   rsp_ch   out        bin_index, status, last
//   csr_*    in         apb registers bin_size, bins_per_axis, total_bins, coord_limit
//
// front: load, serial divide (one quotient bit per cycle), multiply states S_MUL1 and S_MUL2
// back: one neighbor offset per cycle while the rsp output is free, 27 per point after a fetch,
// and a flush when the last candidate is in range and an earlier one was too; an out of bound
// point is answered at its fetch; the back sets the sustained point rate
// a two entry queue lets the front divide the next point while the back lists this one
// reset is synchronous and restores the register reset values; rsp stalls also reach the front
module grid_cell_neighbor_bins import gcnb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   gcnb_req_if.sink          req_ch,
   gcnb_rsp_if.source        rsp_ch,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);
   cfg_type  cfg;
   push_type q_push;
   head_type q_head;
   logic     q_full;
   logic     q_pop;

   gcnb_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .cfg
   );

   gcnb_front u_front (
      .clock, .reset, .req(req_ch), .cfg, .q_full, .q_push
   );

   gcnb_queue u_queue (
      .clock, .reset, .q_push, .q_pop, .q_full, .q_head
   );

   gcnb_back u_back (
      .clock, .reset, .cfg, .q_head, .q_pop, .rsp(rsp_ch)
   );
endmodule

// ===== src/gcnb_csr.sv =====
// configuration registers with apb write and read
// depends on gcnb_pkg
module gcnb_csr import gcnb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);
   logic [BSZ_W-1:0] bsz_ff;
   logic [M_W-1:0]   bpa_ff;
   logic [TOT_W-1:0] tot_ff;
   logic [LIM_W-1:0] lim_ff;
   logic [MM_W-1:0]  mm_ff, mm_in;
   logic [M_W-1:0]   m_c;
   logic             wr;
   logic [1:0]       sel;

   assign csr_pready = 1'b1;
   assign wr  = csr_psel && csr_penable && csr_pwrite;
   assign sel = csr_paddr[3:2];
   assign m_c = (bpa_ff > M_W'(MAX_M)) ? M_W'(MAX_M) : bpa_ff;
   assign mm_in = MM_W'(m_c * m_c);

   always_ff @(posedge clock) begin
      if (reset) begin
         bsz_ff <= BSZ_RESET;
         bpa_ff <= BPA_RESET;
         tot_ff <= TOT_RESET;
         lim_ff <= LIM_RESET;
      end else if (wr) begin
         case (sel)
            REG_BIN_SIZE:   bsz_ff <= csr_pwdata[BSZ_W-1:0];
            REG_BINS_AXIS:  bpa_ff <= csr_pwdata[M_W-1:0];
            REG_TOTAL_BINS: tot_ff <= csr_pwdata[TOT_W-1:0];
            REG_COORD_LIM:  lim_ff <= csr_pwdata[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      mm_ff <= mm_in;
   end

   always_comb begin
      case (sel)
         REG_BIN_SIZE:   csr_prdata = DATA_W'(bsz_ff);
         REG_BINS_AXIS:  csr_prdata = DATA_W'(bpa_ff);
         REG_TOTAL_BINS: csr_prdata = DATA_W'(tot_ff);
         REG_COORD_LIM:  csr_prdata = DATA_W'(lim_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign cfg.dsz  = (bsz_ff == '0) ? BSZ_W'(1) : bsz_ff;
   assign cfg.m    = m_c;
   assign cfg.half = m_c[M_W-1:1];
   assign cfg.mm   = mm_ff;
   assign cfg.tot  = (tot_ff > TOT_CAP) ? TOT_CAP : tot_ff;
   assign cfg.lim  = lim_ff;
endmodule

// ===== src/gcnb_front.sv =====
// front end: input register, bound check, serial floor divide, flattening
// depends on gcnb_pkg and gcnb_req_if
module gcnb_front import gcnb_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   gcnb_req_if.sink  req,
   input  cfg_type   cfg,
   input  logic      q_full,
   output push_type  q_push
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_MUL1 = 2'd2;
   localparam logic [1:0] S_MUL2 = 2'd3;

   logic [1:0]                state_ff, state_in;
   logic                      in_full_ff, in_full_in;
   logic signed [COORD_W-1:0] p_ff [3];
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      neg_ff [3];
   logic [DIV_W-1:0]          dvd_ff [3];
   logic [DIV_W-1:0]          rem_ff [3];
   logic [MAG_W-1:0]          mag [3];
   logic [DIV_W:0]            trial [3];
   logic signed [BIN_W-1:0]   fq [3];
   logic signed [BIN_W-1:0]   b [3];
   logic signed [T_W-1:0]     t0_ff, t1_ff;
   logic signed [BIN_W-1:0]   b2_ff;
   logic signed [CENTER_W-1:0] center_c;
   logic                      err;
   logic                      take;
   logic                      accept;

   assign req.ready = !in_full_ff;
   assign accept    = req.valid && !in_full_ff;

   always_comb begin
      err = 1'b0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = p_ff[i][COORD_W-1] ? MAG_W'(-$signed({p_ff[i][COORD_W-1], p_ff[i]}))
                                     : MAG_W'({1'b0, p_ff[i]});
         if (mag[i] >= MAG_W'(cfg.lim)) err = 1'b1;
         trial[i] = {rem_ff[i], dvd_ff[i][DIV_W-1]};
         fq[i] = neg_ff[i] ? -$signed(BIN_W'(dvd_ff[i])) - $signed(BIN_W'(rem_ff[i] != '0))
                           : $signed(BIN_W'(dvd_ff[i]));
         b[i] = fq[i] + $signed(BIN_W'(cfg.half));
      end
   end

   assign center_c = CENTER_W'(t0_ff) * $signed(CENTER_W'(cfg.m))
                   + CENTER_W'(t1_ff) + CENTER_W'(b2_ff);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      take         = 1'b0;
      q_push.push  = 1'b0;
      q_push.entry.is_err = 1'b0;
      q_push.entry.center = center_c;
      case (state_ff)
         S_IDLE: begin
            if (in_full_ff) begin
               if (err) begin
                  if (!q_full) begin
                     q_push.push = 1'b1;
                     q_push.entry.is_err = 1'b1;
                     take = 1'b1;
                  end
               end else begin
                  take     = 1'b1;
                  cnt_in   = '0;
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_W - 1)) state_in = S_MUL1;
         end
         S_MUL1: state_in = S_MUL2;
         S_MUL2: begin
            if (!q_full) begin
               q_push.push = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign in_full_in = accept ? 1'b1 : (take ? 1'b0 : in_full_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         in_full_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         in_full_ff <= in_full_in;
      end
      cnt_ff <= cnt_in;
      if (accept) begin
         p_ff[0] <= req.pos_x;
         p_ff[1] <= req.pos_y;
         p_ff[2] <= req.pos_z;
      end
      for (int i = 0; i < 3; i++) begin
         if (state_ff == S_IDLE) begin
            neg_ff[i] <= p_ff[i][COORD_W-1];
            dvd_ff[i] <= mag[i][DIV_W-1:0];
            rem_ff[i] <= '0;
         end else if (state_ff == S_DIV) begin
            if (trial[i] >= (DIV_W+1)'(cfg.dsz)) begin
               rem_ff[i] <= DIV_W'(trial[i] - (DIV_W+1)'(cfg.dsz));
               dvd_ff[i] <= {dvd_ff[i][DIV_W-2:0], 1'b1};
            end else begin
               rem_ff[i] <= trial[i][DIV_W-1:0];
               dvd_ff[i] <= {dvd_ff[i][DIV_W-2:0], 1'b0};
            end
         end
      end
      if (state_ff == S_MUL1) begin
         t0_ff <= T_W'(b[0]) * $signed(T_W'(cfg.m));
         t1_ff <= T_W'(b[1]) * $signed(T_W'(cfg.m));
         b2_ff <= b[2];
      end
   end
endmodule

// ===== src/gcnb_queue.sv =====
// two entry queue between front and back
// depends on gcnb_pkg
module gcnb_queue import gcnb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type q_push,
   input  logic     q_pop,
   output logic     q_full,
   output head_type q_head
);
   entry_type  mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff, cnt_in;

   assign q_full       = (cnt_ff == 2'd2);
   assign q_head.valid = (cnt_ff != 2'd0);
   assign q_head.entry = mem_ff[rd_ff];
   assign cnt_in = cnt_ff + 2'(q_push.push) - 2'(q_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (q_push.push) wr_ff <= !wr_ff;
         if (q_pop) rd_ff <= !rd_ff;
      end
      if (q_push.push) mem_ff[wr_ff] <= q_push.entry;
   end
endmodule

// ===== src/gcnb_back.sv =====
// back: walks 27 neighbor offsets; emits in-range bins or status
// depends on gcnb_pkg, gcnb_rsp_if and assert_macros.svh
`include "assert_macros.svh"
module gcnb_back import gcnb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  head_type   q_head,
   output logic       q_pop,
   gcnb_rsp_if.source rsp
);
   logic                       busy_ff, busy_in;
   logic                       flush_ff, flush_in;
   logic                       have_ff, have_in;
   logic [IDX_W-1:0]           held_ff, held_in;
   logic signed [CENTER_W-1:0] center_ff, center_in;
   logic [PL_W-1:0]            pl_ff, pl_in;
   logic [NB_W-1:0]            nb_ff, nb_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]           rsp_idx_ff;
   logic [ST_W-1:0]            rsp_st_ff;
   logic                       rsp_last_ff;
   logic                       out_free;
   logic                       emit;
   logic [IDX_W-1:0]           e_idx;
   logic [ST_W-1:0]            e_st;
   logic                       e_last;
   logic signed [CENTER_W-1:0] pterm, rterm, cterm, cand;
   logic                       ok, last_step;
   logic signed [CENTER_W-1:0] mm_s, m_s;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign mm_s = $signed(CENTER_W'(cfg.mm));
   assign m_s  = $signed(CENTER_W'(cfg.m));

   always_comb begin
      case (pl_ff)
         2'd1:    pterm = mm_s;
         2'd2:    pterm = -mm_s;
         default: pterm = '0;
      endcase
      case (ROW_STEP[nb_ff])
         2'sd1:   rterm = m_s;
         -2'sd1:  rterm = -m_s;
         default: rterm = '0;
      endcase
      cterm = CENTER_W'(COL_STEP[nb_ff]);
      cand  = center_ff + pterm + rterm + cterm;
      ok    = !cand[CENTER_W-1] && (cand < $signed(CENTER_W'(cfg.tot)));
      last_step = (pl_ff == PL_W'(PL_N - 1)) && (nb_ff == NB_W'(NB_N - 1));
   end

   always_comb begin
      busy_in   = busy_ff;
      flush_in  = flush_ff;
      have_in   = have_ff;
      held_in   = held_ff;
      center_in = center_ff;
      pl_in     = pl_ff;
      nb_in     = nb_ff;
      q_pop     = 1'b0;
      emit      = 1'b0;
      e_idx     = held_ff;
      e_st      = ST_OK;
      e_last    = 1'b0;
      if (flush_ff) begin
         if (out_free) begin
            emit     = 1'b1;
            e_last   = 1'b1;
            flush_in = 1'b0;
            have_in  = 1'b0;
         end
      end else if (busy_ff) begin
         if (out_free) begin
            if (nb_ff == NB_W'(NB_N - 1)) begin
               nb_in = '0;
               pl_in = pl_ff + PL_W'(1);
            end else begin
               nb_in = nb_ff + NB_W'(1);
            end
            if (!last_step) begin
               if (ok) begin
                  emit    = have_ff;
                  held_in = cand[IDX_W-1:0];
                  have_in = 1'b1;
               end
            end else begin
               busy_in = 1'b0;
               have_in = 1'b0;
               emit    = 1'b1;
               if (ok && have_ff) begin
                  held_in  = cand[IDX_W-1:0];
                  have_in  = 1'b1;
                  flush_in = 1'b1;
               end else if (ok) begin
                  e_idx  = cand[IDX_W-1:0];
                  e_last = 1'b1;
               end else if (have_ff) begin
                  e_last = 1'b1;
               end else begin
                  e_idx  = '0;
                  e_st   = ST_NONE;
                  e_last = 1'b1;
               end
            end
         end
      end else if (q_head.valid && out_free) begin
         q_pop = 1'b1;
         if (q_head.entry.is_err) begin
            emit   = 1'b1;
            e_idx  = '0;
            e_st   = ST_OOB;
            e_last = 1'b1;
         end else begin
            busy_in   = 1'b1;
            center_in = q_head.entry.center;
            pl_in     = '0;
            nb_in     = '0;
            have_in   = 1'b0;
         end
      end
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         flush_ff     <= 1'b0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         flush_ff     <= flush_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      held_ff   <= held_in;
      center_ff <= center_in;
      pl_ff     <= pl_in;
      nb_ff     <= nb_in;
      if (emit) begin
         rsp_idx_ff  <= e_idx;
         rsp_st_ff   <= e_st;
         rsp_last_ff <= e_last;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.bin_index = rsp_idx_ff;
   assign rsp.status    = rsp_st_ff;
   assign rsp.last      = rsp_last_ff;

   `GCNB_ASSERT(a_walk_or_flush, clock, reset, !(busy_ff && flush_ff), "walk and flush overlap")
   `GCNB_ASSERT(a_held_owner, clock, reset, have_ff |-> (busy_ff || flush_ff), "stale held bin")
   `GCNB_ASSERT(a_status_last, clock, reset, (rsp_valid_ff && rsp_st_ff != ST_OK) |-> (rsp_last_ff && rsp_idx_ff == '0), "status result malformed")
endmodule

// ===== tb/sv/grid_cell_neighbor_bins_test.sv =====
// self-checking testbench for grid_cell_neighbor_bins: random and directed points with
// random stalls on both channels, checked against a behavioral bin predictor
// depends on gcnb_pkg, gcnb_req_if, gcnb_rsp_if and the grid_cell_neighbor_bins rtl
`timescale 1ns / 1ps

module grid_cell_neighbor_bins_test;
   import gcnb_pkg::*;

   typedef struct {
      logic [IDX_W-1:0] bin_index;
      logic [ST_W-1:0]  status;
      logic             last;
   } bin_result_type;

   class bin_scoreboard;
      logic [BSZ_W-1:0] bin_size;
      logic [M_W-1:0]   bins_axis;
      logic [TOT_W-1:0] total_bins;
      logic [LIM_W-1:0] coord_lim;
      bin_result_type   pending[$];
      int               errors;

      function void reset_regs();
         bin_size   = BSZ_RESET;
         bins_axis  = BPA_RESET;
         total_bins = TOT_RESET;
         coord_lim  = LIM_RESET;
      endfunction

      function void write_reg(logic [1:0] sel, logic [DATA_W-1:0] value);
         case (sel)
            REG_BIN_SIZE:   bin_size   = value[BSZ_W-1:0];
            REG_BINS_AXIS:  bins_axis  = value[M_W-1:0];
            REG_TOTAL_BINS: total_bins = value[TOT_W-1:0];
            REG_COORD_LIM:  coord_lim  = value[LIM_W-1:0];
            default: ;
         endcase
      endfunction

      function void push(logic [IDX_W-1:0] idx, logic [ST_W-1:0] st, logic lst);
         bin_result_type r;
         r.bin_index = idx;
         r.status    = st;
         r.last      = lst;
         pending.insert(pending.size(), r);
      endfunction

      function void note_point(logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py,
                               logic signed [COORD_W-1:0] pz);
         longint p[3];
         longint b[3];
         longint d, m, tot, lim, q, center, idx;
         longint plane[3];
         int     found;
         p[0] = px;
         p[1] = py;
         p[2] = pz;
         d    = (bin_size == 0) ? 1 : bin_size;
         m    = (bins_axis > MAX_M) ? MAX_M : bins_axis;
         tot  = (total_bins > TOT_CAP) ? TOT_CAP : total_bins;
         lim  = coord_lim;
         for (int i = 0; i < 3; i++) begin
            if (((p[i] < 0) ? -p[i] : p[i]) >= lim) begin
               push('0, ST_OOB, 1'b1);
               return;
            end
            q = p[i] / d;
            if ((p[i] % d) != 0 && p[i] < 0) q = q - 1;
            b[i] = q + m / 2;
         end
         center   = b[0] * m * m + b[1] * m + b[2];
         plane[0] = 0;
         plane[1] = m * m;
         plane[2] = -m * m;
         found    = 0;
         for (int i = 0; i < PL_N; i++) begin
            for (int j = 0; j < NB_N; j++) begin
               idx = center + plane[i] + longint'(ROW_STEP[j]) * m + longint'(COL_STEP[j]);
               if (idx >= 0 && idx < tot) begin
                  push(idx[IDX_W-1:0], ST_OK, 1'b0);
                  found++;
               end
            end
         end
         if (found == 0) push('0, ST_NONE, 1'b1);
         else pending[pending.size()-1].last = 1'b1;
      endfunction

      function void check(logic [IDX_W-1:0] idx, logic [ST_W-1:0] st, logic lst);
         bin_result_type e;
         if (pending.size() == 0) begin
            $display("%0t unexpected result: bin_index %0d status %0d last %0d",
                     $time, idx, st, lst);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (e.bin_index !== idx) begin
            $display("%0t bin_index mismatch: expected %0d actual %0d", $time, e.bin_index, idx);
            errors++;
         end
         if (e.status !== st) begin
            $display("%0t status mismatch: expected %0d actual %0d", $time, e.status, st);
            errors++;
         end
         if (e.last !== lst) begin
            $display("%0t last mismatch: expected %0d actual %0d", $time, e.last, lst);
            errors++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0] csr_pwdata;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   gcnb_req_if req_ch ();
   gcnb_rsp_if rsp_ch ();

   grid_cell_neighbor_bins dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch.sink),
      .rsp_ch      (rsp_ch.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   bin_scoreboard sb;
   bit            calm;
   int            stall;
   int            idle_cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      sb = new();
      sb.reset_regs();
      reset        = 1'b1;
      calm         = 1'b0;
      stall        = 0;
      idle_cycles  = 0;
      req_ch.valid = 1'b0;
      req_ch.pos_x = '0;
      req_ch.pos_y = '0;
      req_ch.pos_z = '0;
      rsp_ch.ready = 1'b0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
   end

   // result side: random stall per transaction, none while calm
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            sb.check(rsp_ch.bin_index, rsp_ch.status, rsp_ch.last);
            stall = calm ? 0 : $urandom_range(0, 19);
         end else if (stall > 0) begin
            stall--;
         end
         rsp_ch.ready <= (stall == 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= 3000) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_csr(logic [1:0] sel, logic [DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_W'({sel, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      sb.write_reg(sel, value);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   task automatic set_grid(logic [DATA_W-1:0] bsz, logic [DATA_W-1:0] bpa,
                           logic [DATA_W-1:0] tot, logic [DATA_W-1:0] lim);
      drain();
      write_csr(REG_BIN_SIZE, bsz);
      write_csr(REG_BINS_AXIS, bpa);
      write_csr(REG_TOTAL_BINS, tot);
      write_csr(REG_COORD_LIM, lim);
   endtask

   // valid stays high across back-to-back transactions when the random gap is zero
   task automatic send_point(longint x, longint y, longint z);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.pos_x <= x[COORD_W-1:0];
      req_ch.pos_y <= y[COORD_W-1:0];
      req_ch.pos_z <= z[COORD_W-1:0];
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      sb.note_point(x[COORD_W-1:0], y[COORD_W-1:0], z[COORD_W-1:0]);
   endtask

   function automatic longint rand_coord();
      longint r, m;
      if ($urandom_range(0, 9) == 0) return longint'($signed(24'($urandom())));
      m = (sb.bins_axis > MAX_M) ? MAX_M : sb.bins_axis;
      r = longint'((sb.bin_size == 0) ? 1 : sb.bin_size) * (m / 2 + 2);
      if ($urandom_range(0, 3) == 0 || r > 8388607) r = 8388607;
      return longint'($urandom_range(0, 2 * r)) - r;
   endfunction

   task automatic random_points(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 8 == 0) calm = ($urandom_range(0, 3) == 0);
         send_point(rand_coord(), rand_coord(), rand_coord());
      end
      calm = 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_point(0, 0, 0);
      send_point(8388607, 0, 0);
      send_point(0, -8388608, 0);
      send_point(0, 0, -8388607);
      send_point(8388606, 8388606, 8388606);
      send_point(-8388606, -8388606, -8388606);
      send_point(-32768, -32768, -32768);
      send_point(-32769, -32768, -32768);
      send_point(-32768, -32768, -32769);
      send_point(32767, 32767, 32767);
      send_point(32512, 32512, 32512);
      send_point(-1, -1, -1);
      send_point(-256, 255, 256);
      set_grid(1, 4, 64, 8388607);
      send_point(-2, -2, -2);
      send_point(1, 1, 1);
      send_point(-3, -2, -2);
      send_point(-2, -2, -3);
      send_point(2, -1, 0);
      random_points(20);

      // pause until the block is empty
      drain();
      repeat ($urandom_range(5, 40)) @(posedge clock);

      set_grid(3, 2047, 32'h7fff_ffff, 1000);
      random_points(18);
      set_grid(8388607, 1, 1, 8388607);
      random_points(12);
      set_grid(0, 0, 5, 8388607);
      send_point(0, 0, 4);
      send_point(0, 0, 5);
      random_points(12);
      set_grid(16, 1024, 1073741824, 0);
      random_points(6);
      set_grid(1, 2, 8, 1);
      send_point(0, 0, 0);
      random_points(6);
      set_grid($urandom_range(1, 64), $urandom_range(1, 32), $urandom_range(1, 40000),
               $urandom_range(1, 8388607));
      random_points(6);
      set_grid(256, 256, 16777216, 8388607);
      random_points(12);

      drain();
      repeat (60) @(posedge clock);
      if (sb.pending.size() != 0) begin
         $display("%0t %0d expected results never arrived", $time, sb.pending.size());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
